// File: sv/lpd_pkg.sv
package lpd_pkg;

	// Field widths of the byte stream and of the result word.
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W = 32;
	localparam int unsigned HDR_W = 24;
	localparam int unsigned CFG_W = 21;

	// Largest frame payload the block is built for, in bytes.
	localparam int unsigned MAX_FRAME_BYTES_DEF = 1024 * 1024;

	// Depth of the result queue between the parser and the output stage.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One result word as it leaves the block.
	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_start;
		logic              frame_end;
		logic              bad_length;
	} lpd_result_t;

	// Push request from the parser into the queue.
	typedef struct packed {
		logic        push;
		lpd_result_t word;
	} lpd_push_t;

endpackage

// File: sv/length_prefix_deframer.sv
// Length-prefixed deframer. Each input word is one stream byte; four header
// bytes, least significant first, give a 32-bit frame length, followed by that
// many payload bytes that come out with frame_start and frame_end marks.
// A length of zero, with bit 31 set, or above the configured limit (cfg_wdata,
// clipped to MAX_FRAME_BYTES) yields one word with bad_length set, after which
// all bytes are dropped until reset. The block takes one byte per clock:
// in_ready stays high while the four-entry result queue has room. A payload
// byte is written into the queue at the edge that accepts it and moves on to
// the output register, raising out_valid, once that register is empty or being
// taken. Header bytes of a valid length produce no output word.
module length_prefix_deframer
	import lpd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] payload_byte,
	output logic              frame_start,
	output logic              frame_end,
	output logic              bad_length
);

	lpd_push_t   push;
	logic        q_not_empty;
	logic        q_pop;
	lpd_result_t q_head;
	lpd_result_t out_word;

	// Parser and classifier.
	lpd_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.push_o    (push)
	);

	// Result queue between the two halves.
	lpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_i    (push),
		.not_full  (in_ready),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.head      (q_head)
	);

	// Output register stage.
	lpd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word)
	);

	assign payload_byte = out_word.payload_byte;
	assign frame_start  = out_word.frame_start;
	assign frame_end    = out_word.frame_end;
	assign bad_length   = out_word.bad_length;

endmodule

// File: sv/lpd_front.sv
module lpd_front
	import lpd_pkg::*;
#(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	output lpd_push_t         push_o
);

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [CFG_W-1:0] MAX_LIM = CFG_W'(MAX_FRAME_BYTES);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_ERROR   = 2'd2;

	logic [1:0]       phase_q;
	logic [1:0]       hdr_cnt_q;
	logic [HDR_W-1:0] hdr_q;
	logic [CNT_W-1:0] left_q;
	logic             first_q;
	logic [CFG_W-1:0] lim_q;

	logic             accept;
	logic [LEN_W-1:0] len;
	logic             len_bad;
	logic             last;

	assign accept = in_valid && in_ready;

	// The fourth header byte completes the length straight from the input, not from hdr_q.
	assign len     = {in_byte, hdr_q};
	assign len_bad = (len == '0) || len[LEN_W-1] || (len > LEN_W'(lim_q));
	assign last    = (left_q <= CNT_W'(1));

	// Effective limit is kept clipped to the built-in maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= MAX_LIM;
		end else if (cfg_we) begin
			lim_q <= (cfg_wdata > MAX_LIM) ? MAX_LIM : cfg_wdata;
		end
	end

	// Classify the current byte and build its result word, if any.
	always_comb begin
		push_o = '0;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q == 2'd3 && len_bad) begin
					push_o.push = accept;
					push_o.word.bad_length = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				push_o.push = accept;
				push_o.word.payload_byte = in_byte;
				push_o.word.frame_start = first_q;
				push_o.word.frame_end = last;
			end
			default: begin
				push_o.push = 1'b0;
			end
		endcase
	end

	// Parser state advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_q     <= '0;
			left_q    <= '0;
			first_q   <= 1'b0;
		end else if (accept) begin
			unique case (phase_q)
				PH_HEADER: begin
					hdr_q <= {in_byte, hdr_q[HDR_W-1:BYTE_W]};
					if (hdr_cnt_q != 2'd3) begin
						hdr_cnt_q <= hdr_cnt_q + 2'd1;
					end else begin
						hdr_cnt_q <= '0;
						if (len_bad) begin
							phase_q <= PH_ERROR;
						end else begin
							phase_q <= PH_PAYLOAD;
							left_q  <= len[CNT_W-1:0];
							first_q <= 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					first_q <= 1'b0;
					if (last) begin
						left_q    <= '0;
						phase_q   <= PH_HEADER;
						hdr_cnt_q <= '0;
					end else begin
						left_q <= left_q - CNT_W'(1);
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end

	// The error phase is sticky until reset.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left without reset");

	// A frame's last word returns the parser to the header phase.
	a_end_to_header: assert property (@(posedge clk) disable iff (!arst_n)
		push_o.push && push_o.word.frame_end |=> phase_q == PH_HEADER)
		else $error("frame end did not return to header phase");

endmodule

// File: sv/lpd_queue.sv
module lpd_queue
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lpd_push_t   push_i,
	output logic        not_full,
	output logic        not_empty,
	input  logic        pop,
	output lpd_result_t head
);

	lpd_result_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_i.push) begin
			mem_q[wr_q] <= push_i.word;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_i.push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push_i.push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push_i.push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_i.push |-> not_full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from an empty queue");

endmodule

// File: sv/lpd_back.sv
module lpd_back
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_not_empty,
	input  lpd_result_t q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output lpd_result_t out_word
);

	logic        valid_q;
	lpd_result_t word_q;

	// Refill the output register whenever it is empty or being taken.
	assign q_pop     = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			word_q <= q_head;
		end
	end

endmodule
